// ----- hw/rtl/nvst_pkg.sv -----
// ---------------------------------------------------------------------------
// Nearest-value slot table package
// Widths, codes and shared types of the nearest-value slot table.
// ---------------------------------------------------------------------------
package nvst_pkg;

    // Table geometry.
    localparam int SLOTS     = 16;
    localparam int OWNERS    = 16;
    localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Field widths of the request, the result and the capacity register.
    localparam int VALUE_W   = 10;
    localparam int OWNER_W   = 4;
    localparam int CAP_W     = 5;
    localparam int OCC_W     = 5;
    localparam int MASK_W    = 16;
    localparam int LAST_W    = VALUE_W + 1;
    localparam int DIST_W    = VALUE_W + 1;

    // Capacity after reset.
    localparam int CAP_RESET = 16;

    // Request modes.
    localparam logic MODE_POST = 1'b0;
    localparam logic MODE_TAKE = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_POSTED  = 2'd0,
        STATUS_DROPPED = 2'd1,
        STATUS_TAKEN   = 2'd2,
        STATUS_EMPTY   = 2'd3
    } nvst_status_t;

endpackage

// ----- hw/rtl/nvst_req_if.sv -----
// ---------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one post or take request.
// ---------------------------------------------------------------------------
interface nvst_req_if;
    import nvst_pkg::*;

    logic               valid;
    logic               ready;
    logic               mode;
    logic [VALUE_W-1:0] value;
    logic [OWNER_W-1:0] owner;

    modport source (output valid, mode, value, owner, input ready);
    modport sink   (input valid, mode, value, owner, output ready);

endinterface

// ----- hw/rtl/nvst_rsp_if.sv -----
// ---------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the outcome of one request.
// ---------------------------------------------------------------------------
interface nvst_rsp_if;
    import nvst_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [VALUE_W-1:0] taken_value;
    logic [OWNER_W-1:0] taken_owner;
    logic [OCC_W-1:0]   occupancy;
    logic               is_full;
    logic [MASK_W-1:0]  owner_pending_mask;

    modport source (output valid, status, taken_value, taken_owner, occupancy,
                    is_full, owner_pending_mask, input ready);
    modport sink   (input valid, status, taken_value, taken_owner, occupancy,
                    is_full, owner_pending_mask, output ready);

endinterface

// ----- hw/rtl/nearest_value_slot_table_core.sv -----
// ---------------------------------------------------------------------------
// Nearest-value slot table core
// Shortest-seek-first request table: post stores a request in the lowest
// free slot, take removes the request nearest the last value taken.
// ---------------------------------------------------------------------------
// Each request is first taken in; the distance and compare unit then walks
// the table slot by slot from slot 0 up to the last slot within the effective
// capacity, and finally the table is updated and the result register loaded.
// The final step waits for as long as the previous result is still held
// uncollected in the result register. The result register lets the next
// request enter while a result is still waiting to be collected. Capacity
// writes are taken whenever the write enable is high; values of 0 act as 1 and
// values above the slot count act as the slot count. No clearing pass is
// needed after reset.
module nearest_value_slot_table_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [nvst_pkg::CAP_W-1:0] cfg_wr_data,
    nvst_req_if.sink                  req,
    nvst_rsp_if.source                rsp
);
    import nvst_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t state_reg;

    // Table storage: contents have no reset, occupancy flags do.
    logic [VALUE_W-1:0] slot_value_reg [SLOTS];
    logic [OWNER_W-1:0] slot_owner_reg [SLOTS];
    logic [SLOTS-1:0]   slot_valid_reg;

    logic [CAP_W-1:0]   cap_reg;
    logic [LAST_W-1:0]  last_taken_reg;

    // Latched request.
    logic               mode_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [OWNER_W-1:0] owner_reg;

    // Scan state.
    logic [IDX_W-1:0]   idx_reg;
    logic               found_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic [DIST_W-1:0]  best_dist_reg;
    logic [VALUE_W-1:0] best_value_reg;
    logic [OWNER_W-1:0] best_owner_reg;
    logic [OCC_W-1:0]   count_reg;
    logic [OWNERS-1:0]  once_reg;
    logic [OWNERS-1:0]  twice_reg;

    // Result register.
    logic               out_valid_reg;
    nvst_status_t       out_status_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic [OWNER_W-1:0] out_owner_reg;
    logic [OCC_W-1:0]   out_occ_reg;
    logic               out_full_reg;
    logic [MASK_W-1:0]  out_mask_reg;

    // Effective capacity, saturated to the range 1 to SLOTS.
    logic [CAP_W-1:0] cap_eff;

    always_comb
    begin
        if (cap_reg == '0)
            cap_eff = CAP_W'(1);
        else if (cap_reg > CAP_W'(SLOTS))
            cap_eff = CAP_W'(SLOTS);
        else
            cap_eff = cap_reg;
    end

    // Shared distance and compare unit, fed by the slot under the scan index.
    logic                     cur_valid;
    logic [VALUE_W-1:0]       cur_value;
    logic [OWNER_W-1:0]       cur_owner;
    logic signed [VALUE_W+1:0] diff;
    logic [DIST_W-1:0]        seek_dist;
    logic                     better;
    logic                     scan_last;

    assign cur_valid = slot_valid_reg[idx_reg];
    assign cur_value = slot_value_reg[idx_reg];
    assign cur_owner = slot_owner_reg[idx_reg];
    assign diff      = $signed({2'b00, cur_value})
                     - $signed({last_taken_reg[LAST_W-1], last_taken_reg});
    assign seek_dist = diff[VALUE_W+1] ? DIST_W'(-diff) : diff[DIST_W-1:0];
    assign scan_last = (CAP_W'(idx_reg) == (cap_eff - CAP_W'(1)));

    always_comb
    begin
        if (mode_reg == MODE_TAKE)
            better = cur_valid && (!found_reg || (seek_dist < best_dist_reg));
        else
            better = !cur_valid && !found_reg;
    end

    // Owner bookkeeping: owners seen at least once and owners seen at least twice.
    // An owner id beyond the mask shifts out and is never recorded.
    logic [OWNERS-1:0] cur_owner_bit;
    logic [OWNERS-1:0] once_next;
    logic [OWNERS-1:0] twice_next;

    assign cur_owner_bit = cur_valid ? (OWNERS'(1) << cur_owner) : '0;
    assign once_next     = once_reg | cur_owner_bit;
    assign twice_next    = twice_reg | (once_reg & cur_owner_bit);

    // Outcome of the finished scan.
    logic              out_load;
    nvst_status_t      fin_status;
    logic [OCC_W-1:0]  fin_occ;
    logic [OWNERS-1:0] fin_mask;
    logic [OWNERS-1:0] post_owner_bit;
    logic [OWNERS-1:0] best_owner_bit;

    assign out_load       = (state_reg == ST_FINISH) && (!out_valid_reg || rsp.ready);
    assign post_owner_bit = OWNERS'(1) << owner_reg;
    assign best_owner_bit = OWNERS'(1) << best_owner_reg;

    always_comb
    begin
        fin_occ  = count_reg;
        fin_mask = once_reg;
        if (mode_reg == MODE_POST)
        begin
            fin_status = found_reg ? STATUS_POSTED : STATUS_DROPPED;
            if (found_reg)
            begin
                fin_occ  = count_reg + OCC_W'(1);
                fin_mask = once_reg | post_owner_bit;
            end
        end
        else
        begin
            fin_status = found_reg ? STATUS_TAKEN : STATUS_EMPTY;
            if (found_reg)
            begin
                // The owner stays pending only if another of its requests remains.
                fin_occ  = count_reg - OCC_W'(1);
                fin_mask = once_reg & ~(best_owner_bit & ~twice_reg);
            end
        end
    end

    // Sequencer, table flags and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            slot_valid_reg <= '0;
            cap_reg        <= CAP_W'(CAP_RESET);
            last_taken_reg <= '1;
            mode_reg       <= MODE_POST;
            value_reg      <= '0;
            owner_reg      <= '0;
            idx_reg        <= '0;
            found_reg      <= 1'b0;
            best_idx_reg   <= '0;
            best_dist_reg  <= '0;
            best_value_reg <= '0;
            best_owner_reg <= '0;
            count_reg      <= '0;
            once_reg       <= '0;
            twice_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= STATUS_POSTED;
            out_value_reg  <= '0;
            out_owner_reg  <= '0;
            out_occ_reg    <= '0;
            out_full_reg   <= 1'b0;
            out_mask_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                cap_reg <= cfg_wr_data;

            // A collected result frees the register unless a new one loads now.
            if (rsp.valid && rsp.ready && !out_load)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req.valid)
                    begin
                        mode_reg  <= req.mode;
                        value_reg <= req.value;
                        owner_reg <= req.owner;
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                        count_reg <= '0;
                        once_reg  <= '0;
                        twice_reg <= '0;
                        state_reg <= ST_SCAN;
                    end
                end

                ST_SCAN:
                begin
                    if (cur_valid)
                        count_reg <= count_reg + OCC_W'(1);
                    once_reg  <= once_next;
                    twice_reg <= twice_next;
                    if (better)
                    begin
                        found_reg      <= 1'b1;
                        best_idx_reg   <= idx_reg;
                        best_dist_reg  <= seek_dist;
                        best_value_reg <= cur_value;
                        best_owner_reg <= cur_owner;
                    end
                    if (scan_last)
                        state_reg <= ST_FINISH;
                    else
                        idx_reg <= idx_reg + IDX_W'(1);
                end

                ST_FINISH:
                begin
                    if (out_load)
                    begin
                        if (found_reg)
                        begin
                            if (mode_reg == MODE_POST)
                                slot_valid_reg[best_idx_reg] <= 1'b1;
                            else
                            begin
                                slot_valid_reg[best_idx_reg] <= 1'b0;
                                last_taken_reg <= {1'b0, best_value_reg};
                            end
                        end
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= fin_status;
                        out_value_reg  <= (fin_status == STATUS_TAKEN) ? best_value_reg : '0;
                        out_owner_reg  <= (fin_status == STATUS_TAKEN) ? best_owner_reg : '0;
                        out_occ_reg    <= fin_occ;
                        out_full_reg   <= (CAP_W'(fin_occ) == cap_eff);
                        out_mask_reg   <= MASK_W'(fin_mask);
                        state_reg      <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Slot contents are written when a post finds a free slot.
    always_ff @(posedge clk)
    begin
        if (out_load && found_reg && (mode_reg == MODE_POST))
        begin
            slot_value_reg[best_idx_reg] <= value_reg;
            slot_owner_reg[best_idx_reg] <= owner_reg;
        end
    end

    // Channel outputs.
    assign req.ready              = (state_reg == ST_IDLE);
    assign rsp.valid              = out_valid_reg;
    assign rsp.status             = out_status_reg;
    assign rsp.taken_value        = out_value_reg;
    assign rsp.taken_owner        = out_owner_reg;
    assign rsp.occupancy          = out_occ_reg;
    assign rsp.is_full            = out_full_reg;
    assign rsp.owner_pending_mask = out_mask_reg;

    // The scan never looks beyond the effective capacity.
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (CAP_W'(idx_reg) < cap_eff))
        else $error("scan index beyond effective capacity");

    // A chosen take slot is still occupied when the table is updated.
    a_take_slot_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FINISH) && (mode_reg == MODE_TAKE) && found_reg)
        |-> slot_valid_reg[best_idx_reg])
        else $error("take chose an empty slot");

    // A completed take moves the head position to the taken value.
    a_last_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (mode_reg == MODE_TAKE) && found_reg)
        |=> (last_taken_reg == {1'b0, $past(best_value_reg)}))
        else $error("last taken value not updated");

    // Taken fields are zero unless a request was taken, and occupancy fits.
    a_result_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((CAP_W'(out_occ_reg) <= cap_eff)
            && ((out_status_reg == STATUS_TAKEN)
                || ((out_value_reg == '0) && (out_owner_reg == '0)))))
        else $error("inconsistent result fields");

endmodule
